// ===== rtl/core/eup_pkg.sv =====
// eup_pkg: shared types, constants and codes of the eikonal upwind point update.
// No dependencies; imported by every module of the block.
`default_nettype none
package eup_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SP0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SP1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SP2   = 3'd3;

  localparam logic [1:0] ORDER_SECOND = 2'd2;

  // solve status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_NO_NBR   = 2'd2;
  localparam logic [1:0] ST_NEG_DISC = 2'd3;

  localparam logic signed [31:0] INF_CODE = 32'sh7FFF_FFFF;
  localparam logic [31:0]        NEG_SAT  = 32'h8000_0000;

  // accumulator caps
  localparam logic [22:0]        A_CAP = 23'h40_0000;
  localparam logic signed [62:0] B_CAP = 63'sh1000_0000_0000_0000;
  localparam logic [62:0]        C_CAP = 63'h4000_0000_0000_0000;
  localparam logic [52:0]        G_CAP = 53'h10_0000_0000_0000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam logic [QPTR_W:0] QCOUNT_FULL = (QPTR_W+1)'(QUEUE_DEPTH);

  typedef struct packed {
    logic               second;
    logic [2:0][30:0]   spacing;   // zero already mapped to one LSB
  } cfg_t;

  // one classified axis word
  typedef struct packed {
    logic               contrib;
    logic [AXIS_W-1:0]  axis;
    logic signed [37:0] spcp;      // S*K
    logic [34:0]        u;         // |K|
    logic               sp3;       // S is 3
    logic               last;
    logic [30:0]        speed;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [30:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic         start;
    logic [127:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/eup_front.sv =====
// eup_front: accepts axis words, picks the upwind side and forms S and K.
// Depends on eup_pkg.
`default_nettype none
module eup_front import eup_pkg::*; (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [AXIS_W-1:0] axis,
  input  wire logic signed [31:0] minus_near,
  input  wire logic signed [31:0] minus_far,
  input  wire logic signed [31:0] plus_near,
  input  wire logic signed [31:0] plus_far,
  input  wire logic [3:0]        known_flags,
  input  wire logic [30:0]       point_speed,
  input  wire logic              last_axis,
  input  wire cfg_t              cfg,
  input  wire logic              q_full,
  output logic                   push,
  output item_t                  item
);

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    logic signed [32:0] en;
    e  = {v[31], v};
    en = -e;
    mag33 = v[31] ? en : e;
  endfunction

  logic mk, pk, use_minus, fk, sw;
  logic signed [31:0] p1, far;
  logic signed [35:0] p1x, farx, cp, cpn;
  logic signed [37:0] cpx;

  always_comb begin
    mk = known_flags[0] && (minus_near != INF_CODE);
    pk = known_flags[2] && (plus_near != INF_CODE);
    use_minus = mk && !(pk && (mag33(plus_near) < mag33(minus_near)));
    p1  = use_minus ? minus_near : plus_near;
    far = use_minus ? minus_far : plus_far;
    fk  = use_minus ? known_flags[1] : known_flags[3];
    sw  = cfg.second && fk && (far != INF_CODE) && (mag33(far) <= mag33(p1));
    p1x  = {{4{p1[31]}}, p1};
    farx = {{4{far[31]}}, far};
    cp   = sw ? (p1x <<< 2) - farx : (p1x <<< 1);
    cpn  = -cp;
    cpx  = {{2{cp[35]}}, cp};

    item.contrib = (axis < AXIS_W'(NUM_AXES)) && (mk || pk);
    item.axis    = axis;
    item.spcp    = sw ? (cpx <<< 1) + cpx : (cpx <<< 1);
    item.u       = cp[35] ? cpn[34:0] : cp[34:0];
    item.sp3     = sw;
    item.last    = last_axis;
    item.speed   = point_speed;
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

// ===== rtl/core/eup_queue.sv =====
// eup_queue: short word queue between the classifying front and the solver back.
// Depends on eup_pkg.
`default_nettype none
module eup_queue import eup_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == QCOUNT_FULL);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eup_mul.sv =====
// eup_mul: 64x64 unsigned multiplier, one 64x16 partial product per cycle.
// Depends on eup_pkg.
`default_nettype none
module eup_mul import eup_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy, done;
  logic [79:0]  pp;
  logic [143:0] sum;

  always_comb begin
    pp  = a_r * b_r[15:0];
    // add at the top, shift right: digit k lands at weight 16*k
    sum = {16'b0, acc} + {pp, 64'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        a_r  <= req.a;
        b_r  <= req.b;
      end else if (busy) begin
        acc <= sum[143:16];
        b_r <= b_r >> 16;
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule
`default_nettype wire

// ===== rtl/core/eup_div.sv =====
// eup_div: 64 by 31 bit unsigned restoring divider, one quotient bit per cycle.
// Depends on eup_pkg.
`default_nettype none
module eup_div import eup_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [63:0] num_r, quo;
  logic [30:0] den_r, rem;
  logic [5:0]  cnt;
  logic        busy, done;
  logic [31:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem, num_r[63]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        num_r <= req.num;
        den_r <= req.den;
      end else if (busy) begin
        rem   <= ge ? rem_sub[30:0] : rem_sh[30:0];
        quo   <= {quo[62:0], ge};
        num_r <= num_r << 1;
        cnt   <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

// ===== rtl/core/eup_sqrt.sv =====
// eup_sqrt: floor square root of a 128-bit value, one root bit per cycle.
// Depends on eup_pkg.
`default_nettype none
module eup_sqrt import eup_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic [127:0] rad_r;
  logic [65:0]  rem;
  logic [63:0]  root;
  logic [5:0]   cnt;
  logic         busy, done;
  logic [67:0]  rem_sh, trial, rem_sub;
  logic         ge;

  always_comb begin
    rem_sh  = {rem, rad_r[127:126]};
    trial   = {2'b0, root, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        root  <= '0;
        rad_r <= req.rad;
      end else if (busy) begin
        rem   <= ge ? rem_sub[65:0] : rem_sh[65:0];
        root  <= {root[62:0], ge};
        rad_r <= rad_r << 2;
        cnt   <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = root;

endmodule
`default_nettype wire

// ===== rtl/core/eup_back.sv =====
// eup_back: sequencer that weights each axis word, accumulates the quadratic
// coefficients and solves on the last axis. Depends on eup_pkg and drives
// eup_mul, eup_div and eup_sqrt through request/response structs.
`default_nettype none
module eup_back import eup_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire item_t     head,
  input  wire logic      q_empty,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic signed [31:0] new_phi,
  output logic [1:0]     solve_status,
  output mul_req_t       mul_req,
  input  wire mul_rsp_t  mul_rsp,
  output div_req_t       div_req,
  input  wire div_rsp_t  div_rsp,
  output sqrt_req_t      sqrt_req,
  input  wire sqrt_rsp_t sqrt_rsp
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_WDIV_Q  = 20'h00002,
    S_WMUL_R  = 20'h00004,
    S_LIN     = 20'h00008,
    S_WMUL_RU = 20'h00010,
    S_WMUL_C  = 20'h00020,
    S_ENDITEM = 20'h00040,
    S_WDIV_G  = 20'h00080,
    S_WMUL_BB = 20'h00100,
    S_WMUL_GG = 20'h00200,
    S_WMUL_AG = 20'h00400,
    S_WMUL_AC = 20'h00800,
    S_CMP     = 20'h01000,
    S_WSQRT   = 20'h02000,
    S_QUOT    = 20'h04000,
    S_WDIV_P  = 20'h08000,
    S_WMUL_DD = 20'h10000,
    S_WMUL_AA = 20'h20000,
    S_WMUL_M  = 20'h40000,
    S_EMIT    = 20'h80000
  } state_t;

  state_t state;

  logic [22:0]        coef_quad;
  logic signed [61:0] coef_lin;
  logic [62:0]        coef_const;

  logic [16:0]        r;
  logic signed [55:0] badd;
  logic [20:0]        aadd;
  logic [52:0]        g;
  logic [61:0]        dd;
  logic [127:0]       p, n;
  logic [63:0]        s;
  logic               fallback, neg;
  logic signed [31:0] res_phi;
  logic [1:0]         res_status;

  // combinational helpers
  logic [30:0]        dmin, dmax, ax_sp;
  logic signed [55:0] badd_w;
  logic [20:0]        aadd_w;
  logic [23:0]        a_sum;
  logic signed [62:0] b_sum;
  logic [63:0]        c_sum, cadd;
  logic [22:0]        a_upd;
  logic signed [61:0] b_upd, b_neg;
  logic [62:0]        c_upd;
  logic [63:0]        b_abs;
  logic signed [65:0] t_sum, t_neg;
  logic [65:0]        t_num;
  logic [127:0]       npm;
  logic [31:0]        q_sat, q_low_neg;

  always_comb begin
    dmin = cfg.spacing[0];
    dmax = cfg.spacing[0];
    for (int i = 1; i < NUM_AXES; i++) begin
      if (cfg.spacing[i] < dmin) dmin = cfg.spacing[i];
      if (cfg.spacing[i] > dmax) dmax = cfg.spacing[i];
    end
    case (head.axis)
      2'd1:    ax_sp = cfg.spacing[1];
      2'd2:    ax_sp = cfg.spacing[2];
      default: ax_sp = cfg.spacing[0];
    endcase

    badd_w = $signed({1'b0, r}) * head.spcp;
    aadd_w = head.sp3 ? ({4'b0, r} << 3) + {4'b0, r} : {4'b0, r} << 2;

    cadd  = mul_rsp.prod[87:24];
    a_sum = {1'b0, coef_quad} + {3'b0, aadd};
    a_upd = (a_sum > {1'b0, A_CAP}) ? A_CAP : a_sum[22:0];
    b_sum = {coef_lin[61], coef_lin} + {{7{badd[55]}}, badd};
    if (b_sum > B_CAP)       b_upd = B_CAP[61:0];
    else if (b_sum < -B_CAP) b_upd = -B_CAP[61:0];
    else                     b_upd = b_sum[61:0];
    c_sum = {1'b0, coef_const} + cadd;
    c_upd = (c_sum > {1'b0, C_CAP}) ? C_CAP : c_sum[62:0];

    b_neg = -coef_lin;
    b_abs = {2'b0, (coef_lin[61] ? b_neg : coef_lin)};

    // floor((B + s) / A): a negative sum takes the ceiling of its magnitude
    t_sum = {{4{coef_lin[61]}}, coef_lin} + {2'b0, s};
    t_neg = -t_sum;
    t_num = t_sum[65] ? t_neg + {43'b0, coef_quad} - 66'd1 : t_sum;

    npm = n - p;

    q_low_neg = ~div_rsp.quo[31:0] + 32'd1;
    if (neg) q_sat = (div_rsp.quo >= 64'h8000_0000) ? NEG_SAT : q_low_neg;
    else     q_sat = (div_rsp.quo >= 64'h7FFF_FFFF) ? INF_CODE : div_rsp.quo[31:0];
  end

  assign pop = (state == S_ENDITEM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      coef_quad  <= '0;
      coef_lin   <= '0;
      coef_const <= '0;
      out_valid  <= 1'b0;
      mul_req.start  <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
    end else begin
      // start strobes last one cycle; no state issues a new one while high
      if (mul_req.start)  mul_req.start  <= 1'b0;
      if (div_req.start)  div_req.start  <= 1'b0;
      if (sqrt_req.start) sqrt_req.start <= 1'b0;
      if (out_valid && out_ready && (state != S_EMIT)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (head.contrib) begin
              div_req <= '{start: 1'b1, num: {2'b0, dmin, 31'b0}, den: ax_sp};
              state   <= S_WDIV_Q;
            end else begin
              state <= S_ENDITEM;
            end
          end
        end
        S_WDIV_Q: begin
          if (div_rsp.done) begin
            mul_req <= '{start: 1'b1, a: div_rsp.quo, b: div_rsp.quo};
            state   <= S_WMUL_R;
          end
        end
        S_WMUL_R: begin
          if (mul_rsp.done) begin
            r     <= mul_rsp.prod[62:46];
            state <= S_LIN;
          end
        end
        S_LIN: begin
          badd    <= badd_w;
          aadd    <= aadd_w;
          mul_req <= '{start: 1'b1, a: {47'b0, r}, b: {29'b0, head.u}};
          state   <= S_WMUL_RU;
        end
        S_WMUL_RU: begin
          if (mul_rsp.done) begin
            mul_req <= '{start: 1'b1, a: mul_rsp.prod[63:0], b: {29'b0, head.u}};
            state   <= S_WMUL_C;
          end
        end
        S_WMUL_C: begin
          if (mul_rsp.done) begin
            coef_quad  <= a_upd;
            coef_lin   <= b_upd;
            coef_const <= c_upd;
            state      <= S_ENDITEM;
          end
        end
        S_ENDITEM: begin
          if (!head.last) begin
            state <= S_IDLE;
          end else if (coef_quad == '0) begin
            res_phi    <= INF_CODE;
            res_status <= ST_NO_NBR;
            state      <= S_EMIT;
          end else if (head.speed == '0) begin
            g       <= G_CAP;
            mul_req <= '{start: 1'b1, a: b_abs, b: b_abs};
            state   <= S_WMUL_BB;
          end else begin
            div_req <= '{start: 1'b1, num: {8'b0, dmin, 25'b0}, den: head.speed};
            state   <= S_WDIV_G;
          end
        end
        S_WDIV_G: begin
          if (div_rsp.done) begin
            g       <= (div_rsp.quo > {11'b0, G_CAP}) ? G_CAP : div_rsp.quo[52:0];
            mul_req <= '{start: 1'b1, a: b_abs, b: b_abs};
            state   <= S_WMUL_BB;
          end
        end
        S_WMUL_BB: begin
          if (mul_rsp.done) begin
            p       <= mul_rsp.prod;
            mul_req <= '{start: 1'b1, a: {11'b0, g}, b: {11'b0, g}};
            state   <= S_WMUL_GG;
          end
        end
        S_WMUL_GG: begin
          // G^2 wraps at 64 bits
          if (mul_rsp.done) begin
            mul_req <= '{start: 1'b1, a: {41'b0, coef_quad}, b: mul_rsp.prod[63:0]};
            state   <= S_WMUL_AG;
          end
        end
        S_WMUL_AG: begin
          if (mul_rsp.done) begin
            p       <= p + mul_rsp.prod;
            mul_req <= '{start: 1'b1, a: {41'b0, coef_quad}, b: {1'b0, coef_const}};
            state   <= S_WMUL_AC;
          end
        end
        S_WMUL_AC: begin
          if (mul_rsp.done) begin
            n     <= mul_rsp.prod << 24;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (n <= p) begin
            fallback <= 1'b0;
            sqrt_req <= '{start: 1'b1, rad: p - n};
            state    <= S_WSQRT;
          end else if (cfg.second) begin
            mul_req <= '{start: 1'b1, a: {33'b0, dmax}, b: {33'b0, dmax}};
            state   <= S_WMUL_DD;
          end else begin
            res_phi    <= INF_CODE;
            res_status <= ST_NEG_DISC;
            state      <= S_EMIT;
          end
        end
        S_WSQRT: begin
          if (sqrt_rsp.done) begin
            s     <= sqrt_rsp.root;
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          neg     <= t_sum[65];
          div_req <= '{start: 1'b1, num: t_num[63:0], den: {8'b0, coef_quad}};
          state   <= S_WDIV_P;
        end
        S_WDIV_P: begin
          if (div_rsp.done) begin
            res_phi    <= q_sat;
            res_status <= fallback ? ST_FALLBACK : ST_OK;
            state      <= S_EMIT;
          end
        end
        S_WMUL_DD: begin
          if (mul_rsp.done) begin
            dd      <= mul_rsp.prod[61:0];
            mul_req <= '{start: 1'b1, a: {41'b0, coef_quad}, b: {41'b0, coef_quad}};
            state   <= S_WMUL_AA;
          end
        end
        S_WMUL_AA: begin
          if (mul_rsp.done) begin
            mul_req <= '{start: 1'b1, a: {2'b0, dd}, b: mul_rsp.prod[63:0]};
            state   <= S_WMUL_M;
          end
        end
        S_WMUL_M: begin
          if (mul_rsp.done) begin
            if (npm <= mul_rsp.prod) begin
              s        <= '0;
              fallback <= 1'b1;
              state    <= S_QUOT;
            end else begin
              res_phi    <= INF_CODE;
              res_status <= ST_NEG_DISC;
              state      <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            new_phi      <= res_phi;
            solve_status <= res_status;
            out_valid    <= 1'b1;
            coef_quad    <= '0;
            coef_lin     <= '0;
            coef_const   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_quad_cap: assert property (@(posedge clk) disable iff (rst)
    coef_quad <= A_CAP)
    else $error("coef_quad above cap");

  a_lin_cap: assert property (@(posedge clk) disable iff (rst)
    (coef_lin <= $signed(B_CAP[61:0])) && (coef_lin >= -$signed(B_CAP[61:0])))
    else $error("coef_lin outside clamp");

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    !(mul_req.start && mul_rsp.busy) && !(div_req.start && div_rsp.busy)
      && !(sqrt_req.start && sqrt_rsp.busy))
    else $error("unit started while busy");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (coef_quad == '0) && (coef_lin == '0) && (coef_const == '0))
    else $error("coefficients not cleared with result");

endmodule
`default_nettype wire

// ===== rtl/core/eikonal_upwind_point_update_top.sv =====
// Top level of the eikonal upwind point update: configuration registers,
// front, queue, sequencer and its multiply, divide and square-root units.
// Depends on eup_pkg and all eup_* modules.
//
// Use: a grid point is sent as a run of axis words on the in_* channel
// (valid/ready), the final word with last_axis set. Each word with a known
// neighbour on a valid axis picks the upwind one and adds to the A, B, C
// coefficients; the last word solves A*phi^2 - 2*B*phi + C = G^2, G from the
// speed, and yields one word on the out channel: new_phi (Q16.16, 0x7FFFFFFF
// is infinity) and solve_status. Words without last_axis give no output word.
// Flow: the front takes a word per cycle into a four-entry queue while the
// queue is not full. The back works one word at a time: a contributing word
// runs the divider for the axis weight and three multiplies; one that adds
// nothing just leaves the queue. The last word of a point then runs the speed
// divide, four multiplies, square root and root divide (no speed divide at zero
// speed; three more multiplies in place of the square root on the second-order
// fallback). The divider and square-root units are 64-step iterative units.
// Reset: synchronous, clears the coefficients, queue and output valid;
// registers return to first order, spacing 1.0. cfg_ready is always high;
// write configuration only while idle.
// Stall: a result waits in the output register; the back keeps working on
// the next point and only holds when it has another result to hand over.
`default_nettype none
module eikonal_upwind_point_update_top import eup_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [AXIS_W-1:0]    axis,
  input  wire logic signed [31:0]   minus_near,
  input  wire logic signed [31:0]   minus_far,
  input  wire logic signed [31:0]   plus_near,
  input  wire logic signed [31:0]   plus_far,
  input  wire logic [3:0]           known_flags,
  input  wire logic [30:0]          point_speed,
  input  wire logic                 last_axis,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        new_phi,
  output logic [1:0]                solve_status
);

  // configuration registers
  logic [1:0]  accuracy_order;
  logic [30:0] spacing_axis0, spacing_axis1, spacing_axis2;
  cfg_t        cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy_order <= 2'd1;
      spacing_axis0  <= 31'd65536;
      spacing_axis1  <= 31'd65536;
      spacing_axis2  <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORDER: accuracy_order <= cfg_data[1:0];
        CFG_SP0:   spacing_axis0  <= cfg_data[30:0];
        CFG_SP1:   spacing_axis1  <= cfg_data[30:0];
        CFG_SP2:   spacing_axis2  <= cfg_data[30:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // zero spacing acts as one LSB
  always_comb begin
    cfg.second     = (accuracy_order == ORDER_SECOND);
    cfg.spacing[0] = (spacing_axis0 == '0) ? 31'd1 : spacing_axis0;
    cfg.spacing[1] = (spacing_axis1 == '0) ? 31'd1 : spacing_axis1;
    cfg.spacing[2] = (spacing_axis2 == '0) ? 31'd1 : spacing_axis2;
  end

  logic      push, q_full, q_empty, pop;
  item_t     push_item, head;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  eup_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .axis        (axis),
    .minus_near  (minus_near),
    .minus_far   (minus_far),
    .plus_near   (plus_near),
    .plus_far    (plus_far),
    .known_flags (known_flags),
    .point_speed (point_speed),
    .last_axis   (last_axis),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .item        (push_item)
  );

  eup_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  eup_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  eup_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  eup_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  eup_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_phi      (new_phi),
    .solve_status (solve_status),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .sqrt_req     (sqrt_req),
    .sqrt_rsp     (sqrt_rsp)
  );

endmodule
`default_nettype wire

// ===== verif/eikonal_upwind_point_update_top_tb.sv =====
// Testbench for eikonal_upwind_point_update_top: random and directed axis words,
// checked against a built-in fixed-point solver of the upwind quadratic update.
// Depends on eup_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none
module eikonal_upwind_point_update_top_tb;
  import eup_pkg::*;

  localparam int      SETTLE_CYCLES = 1000;     // time for up to five result-free words
  localparam longint  CYCLE_LIMIT   = 3000000;
  localparam int      HOLD_CYCLES   = 3000;     // long receiver stall
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  // one axis word as driven on the input channel
  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic signed [31:0] mn;
    logic signed [31:0] mf;
    logic signed [31:0] pn;
    logic signed [31:0] pf;
    logic [3:0]         flags;
    logic [30:0]        speed;
    logic               last;
  } axis_word_t;

  typedef struct packed {
    logic signed [31:0] phi;
    logic [1:0]         status;
  } solve_word_t;

  // Solver model: accumulates the A, B, C coefficients per point and
  // predicts the solve word for each word that ends a point.
  class phi_scoreboard;
    logic [1:0]   order;
    logic [30:0]  spc [3];
    logic [63:0]  quad, cnst;
    longint       lin;
    solve_word_t  pending_phi [$];
    int           errors;
    int           solved;

    function new();
      order = 2'd1;
      for (int i = 0; i < 3; i++) spc[i] = 31'd65536;
      quad = '0; cnst = '0; lin = 0;
      errors = 0; solved = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_ORDER: order = d[1:0];
        CFG_SP0:   spc[0] = d[30:0];
        CFG_SP1:   spc[1] = d[30:0];
        CFG_SP2:   spc[2] = d[30:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_phi.size();
    endfunction

    function logic [63:0] spacing_of(int i);
      return spc[i] == 0 ? 64'd1 : 64'(spc[i]);
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [63:0] isqrt(logic [127:0] d);
      logic [63:0] res, cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= d) res = cand;
      end
      return res;
    endfunction

    // (num + s) / den toward minus infinity, saturated to Q16.16 range
    function logic signed [31:0] floor_div(longint num, logic [63:0] s, logic [63:0] den);
      logic [127:0] qq;
      if (num >= 0 || s >= mag(num)) begin
        qq = (num >= 0) ? (128'(num) + 128'(s)) / 128'(den)
                        : 128'(s - mag(num)) / 128'(den);
        return qq >= 128'(INF_CODE) ? INF_CODE : qq[31:0];
      end
      qq = (128'(mag(num)) - 128'(s) + 128'(den) - 1) / 128'(den);
      return qq >= 128'h8000_0000 ? NEG_SAT : -qq[31:0];
    endfunction

    function void note_word(axis_word_t w);
      logic [63:0]  dmin, dmax, q, r, u, aadd, cadd, g, gg;
      longint       mn, mf, pn, pf, p1, far, cp, sp, badd;
      logic         mk, pk, fk, sw, second;
      logic [127:0] p, n;
      solve_word_t  res;
      second = (order == ORDER_SECOND);
      dmin = spacing_of(0);
      dmax = dmin;
      for (int i = 1; i < NUM_AXES; i++) begin
        if (spacing_of(i) < dmin) dmin = spacing_of(i);
        if (spacing_of(i) > dmax) dmax = spacing_of(i);
      end
      if (w.axis < NUM_AXES) begin
        mn = w.mn; mf = w.mf; pn = w.pn; pf = w.pf;
        // a flagged infinity is still unknown
        mk = w.flags[0] && mn != INF_CODE;
        pk = w.flags[2] && pn != INF_CODE;
        if (mk || pk) begin
          if (mk && !(pk && mag(pn) < mag(mn))) begin
            p1 = mn; far = mf; fk = w.flags[1];
          end else begin
            p1 = pn; far = pf; fk = w.flags[3];
          end
          sw = second && fk && far != INF_CODE && mag(far) <= mag(p1);
          cp = sw ? 4 * p1 - far : 2 * p1;
          sp = sw ? 3 : 2;
          q = (dmin << 31) / spacing_of(w.axis);
          r = (q * q) >> 46;
          aadd = r * 64'(sp * sp);
          quad = (quad + aadd > 64'(A_CAP)) ? 64'(A_CAP) : quad + aadd;
          badd = longint'(r) * sp * cp;
          lin += badd;
          if (lin > longint'(B_CAP)) lin = B_CAP;
          if (lin < -longint'(B_CAP)) lin = -longint'(B_CAP);
          u = mag(cp);
          cadd = 64'((128'(r * u) * 128'(u)) >> 24);
          cnst = (cnst + cadd > 64'(C_CAP)) ? 64'(C_CAP) : cnst + cadd;
        end
      end
      if (!w.last) return;
      res.phi = INF_CODE;
      res.status = ST_OK;
      if (quad == 0) begin
        res.status = ST_NO_NBR;
      end else begin
        g = (w.speed == 0) ? 64'(G_CAP) : (dmin << 25) / 64'(w.speed);
        if (g > 64'(G_CAP)) g = G_CAP;
        gg = g * g;    // 64-bit wrap is part of the arithmetic
        p = 128'(mag(lin)) * 128'(mag(lin)) + 128'(quad) * 128'(gg);
        n = (128'(quad) * 128'(cnst)) << 24;
        if (n <= p)
          res.phi = floor_div(lin, isqrt(p - n), quad);
        else if (second && (n - p) <= 128'(dmax * dmax) * 128'(quad * quad)) begin
          res.phi = floor_div(lin, 64'd0, quad);
          res.status = ST_FALLBACK;
        end else
          res.status = ST_NEG_DISC;
      end
      pending_phi.push_back(res);
      quad = '0; cnst = '0; lin = 0;
    endfunction

    function void check_result(logic signed [31:0] phi, logic [1:0] status);
      solve_word_t e;
      solved++;
      if (pending_phi.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word phi=%0d status=%0d", phi, status);
        return;
      end
      e = pending_phi.pop_front();
      if (phi !== e.phi || status !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: phi exp %0d got %0d, status exp %0d got %0d",
                   solved, e.phi, phi, e.status, status);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid, in_ready;
  axis_word_t           drv;
  logic                 out_valid, out_ready;
  logic signed [31:0]   new_phi;
  logic [1:0]           solve_status;

  phi_scoreboard sb = new();
  longint cycles = 0;
  int     words_sent = 0;
  int     burst_tx, burst_rx;   // nonzero: side runs without idle cycles
  bit     tx_done = 1'b0;

  always #5 clk = ~clk;

  eikonal_upwind_point_update_top i_dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .axis(drv.axis), .minus_near(drv.mn), .minus_far(drv.mf),
    .plus_near(drv.pn), .plus_far(drv.pf), .known_flags(drv.flags),
    .point_speed(drv.speed), .last_axis(drv.last),
    .out_valid, .out_ready, .new_phi, .solve_status
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random ready gaps, plus one long hold-off once traffic is
  // flowing so the queue fills and in_ready drops.
  initial begin : result_side
    int  gap;
    bit  held;
    held = 1'b0;
    out_ready = 1'b0;
    burst_rx = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (burst_rx > 0) begin
        gap = 0; burst_rx--;
      end else begin
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 30) == 0) burst_rx = $urandom_range(10, 40);
      end
      if (!held && sb.solved >= 40) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      repeat (gap) @(negedge clk) out_ready <= 1'b0;
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_result(new_phi, solve_status);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Wait for every due result, then let the back finish words that yield none.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(axis_word_t w);
    int gap;
    if (burst_tx > 0) begin
      gap = 0; burst_tx--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 30) == 0) burst_tx = $urandom_range(10, 40);
    end
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    drv      <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_dir(logic [AXIS_W-1:0] ax, logic signed [31:0] mn, mf, pn, pf,
                          logic [3:0] fl, logic [30:0] spd, logic lst);
    axis_word_t w;
    w = '{ax, mn, mf, pn, pf, fl, spd, lst};
    send_word(w);
  endtask

  function automatic logic signed [31:0] pick_phi();
    logic signed [31:0] v;
    case ($urandom_range(0, 11))
      0:       v = INF_CODE;
      1:       v = NEG_SAT;
      2, 3:    v = $urandom;
      4:       v = 0;
      default: begin
        v = $urandom_range(0, 8 * 65536);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // far neighbour: mostly no larger than the near one, so second order kicks in
  function automatic logic signed [31:0] pick_far(logic signed [31:0] nv);
    if ($urandom_range(0, 3) == 0) return pick_phi();
    if (nv == INF_CODE || nv == NEG_SAT) return $urandom_range(0, 65536);
    return nv - (nv / 4) * $urandom_range(0, 4) / 2;
  endfunction

  function automatic logic [30:0] pick_speed();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 31'd1;
      2:       return 31'h7FFF_FFFF;
      3:       return 31'($urandom);
      default: return 31'($urandom_range(16384, 4 * 65536));
    endcase
  endfunction

  // One grid point: mostly a clean run over distinct axes; sometimes noise
  // with bad axes and stray last bits.
  task automatic send_point();
    axis_word_t w;
    int  cnt, a0;
    bit  noisy;
    cnt   = $urandom_range(1, 3);
    a0    = $urandom_range(0, NUM_AXES - 1);
    noisy = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < cnt; k++) begin
      w.axis  = noisy ? AXIS_W'($urandom_range(0, 3)) : AXIS_W'((a0 + k) % NUM_AXES);
      w.mn    = pick_phi();
      w.pn    = pick_phi();
      w.mf    = pick_far(w.mn);
      w.pf    = pick_far(w.pn);
      w.flags = 4'($urandom);
      if ($urandom_range(0, 3) != 0) w.flags[$urandom_range(0, 1) * 2] = 1'b1;
      w.speed = pick_speed();
      w.last  = noisy ? 1'($urandom_range(0, 1)) : (k == cnt - 1);
      send_word(w);
    end
  endtask

  task automatic random_phase(int n_words);
    int start;
    start = words_sent;
    while (words_sent - start < n_words) send_point();
    @(negedge clk) in_valid <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    drv       = '0;
    burst_tx  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed words, reset configuration (first order, unit spacing)
    send_dir(0, 0, 0, 0, 0, 4'h0, 31'd65536, 1);                // nothing known
    send_dir(0, 65536, 0, 0, 0, 4'h1, 31'd65536, 1);            // minus side only
    send_dir(1, -65536, 0, 65536, 0, 4'h5, 31'd65536, 1);       // tie, minus wins
    send_dir(2, INF_CODE, 0, 3 * 65536, 0, 4'h5, 31'd65536, 1); // flagged infinity
    send_dir(2, 32'sh7FFF_FFFE, NEG_SAT, NEG_SAT, 32'sh7FFF_FFFE, 4'hF,
             31'h7FFF_FFFF, 1);                                 // field extremes
    send_dir(NUM_AXES, 65536, 0, 65536, 0, 4'hF, 31'd65536, 1); // bad axis only
    send_dir(0, 65536, 0, 0, 0, 4'h1, 0, 0);                    // three axes, zero speed
    send_dir(1, 0, 0, 2 * 65536, 0, 4'h4, 0, 0);
    send_dir(2, 65536, 0, 65536, 0, 4'h5, 31'd0, 1);
    send_dir(0, 5 * 65536, 0, 4 * 65536, 0, 4'h5, 31'd1, 0);     // crawling speed
    send_dir(1, 5 * 65536, 0, 4 * 65536, 0, 4'h5, 31'd1, 1);
    send_dir(NUM_AXES, 65536, 0, 0, 0, 4'h1, 31'd65536, 0);      // bad axis mid-point
    send_dir(0, -5 * 65536, 0, 0, 0, 4'h1, 31'd65536, 1);       // negative arrival
    send_dir(0, $urandom, $urandom, $urandom, $urandom, 4'hA, 31'h5555_5555, 1);
    @(negedge clk) in_valid <= 1'b0;
    drain();

    // second order, unit spacing; far values used and ignored
    write_reg(CFG_ORDER, 32'd2);
    send_dir(0, 2 * 65536, 65536, 0, 0, 4'h3, 31'd65536, 1);    // far used
    send_dir(0, 2 * 65536, 3 * 65536, 0, 0, 4'h3, 31'd65536, 1); // far larger
    send_dir(1, 0, 0, 2 * 65536, INF_CODE, 4'hC, 31'd65536, 1); // far infinite
    send_dir(0, 65536, 65536, 0, 0, 4'h3, 31'd65536, 0);
    send_dir(1, 10 * 65536, 10 * 65536, 0, 0, 4'h3, 31'd65536, 1); // skewed pair
    @(negedge clk) in_valid <= 1'b0;
    drain();
    random_phase(260);

    // spacing extremes: the axis-1 weight truncates to zero
    write_reg(CFG_SP0, 32'd1);
    write_reg(CFG_SP1, 32'h7FFF_FFFF);
    write_reg(CFG_SP2, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    random_phase(120);

    // order 0 acts as first order; uneven spacing
    write_reg(CFG_ORDER, 32'd0);
    write_reg(CFG_SP0, 32'd32768);
    write_reg(CFG_SP1, 32'd65536);
    write_reg(CFG_SP2, 32'd131072);
    random_phase(240);

    // order 3 acts as first order; upper data bits ignored
    write_reg(CFG_ORDER, 32'hFFFF_FFFF);
    write_reg(CFG_SP0, 32'h8001_0000);
    write_reg(CFG_SP1, 32'hFFFF_0000);
    write_reg(CFG_SP2, 32'h8000_8000);
    random_phase(240);

    write_reg(CFG_ORDER, 32'd1);
    write_reg(CFG_SP0, $urandom_range(16384, 262144));
    write_reg(CFG_SP1, $urandom_range(16384, 262144));
    write_reg(CFG_SP2, $urandom_range(16384, 262144));
    random_phase(240);

    write_reg(CFG_ORDER, 32'd2);
    write_reg(CFG_SP0, $urandom_range(16384, 262144));
    write_reg(CFG_SP1, $urandom_range(16384, 262144));
    write_reg(CFG_SP2, $urandom_range(16384, 262144));
    random_phase(280);

    $display("covered %0d axis words and %0d solved points over six register settings,",
             words_sent, sb.solved);
    $display("both orders, spacing extremes and a %0d-cycle output stall; %0d errors",
             HOLD_CYCLES, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
